>>> rtl/vdl_pkg.sv
package vdl_pkg;

    // Action codes of an input transaction
    localparam logic [1:0] ACT_SET  = 2'd0;
    localparam logic [1:0] ACT_TICK = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    // Register indexes on the configuration port (paddr[2])
    localparam logic REG_LIMIT = 1'b0;
    localparam logic REG_MASK  = 1'b1;

    // Register reset values
    localparam logic [7:0] LIMIT_RESET = 8'd30;
    localparam logic [7:0] MASK_RESET  = 8'd240;

    // Command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // Fixed port-to-segment map of the drive byte
    localparam logic [2:0] SEG_OF_PORT [8] = '{
        3'd0, 3'd1, 3'd2, 3'd7, 3'd4, 3'd5, 3'd6, 3'd3
    };

    typedef enum logic [1:0] {
        KIND_SET  = 2'd0,
        KIND_TICK = 2'd1,
        KIND_READ = 2'd2
    } t_kind;

    typedef struct packed {
        logic [1:0] action;
        logic [2:0] port;
        logic       turn_on;
    } t_in;

    typedef struct packed {
        logic [7:0] status_bits;
        logic [7:0] resting_bits;
        logic [7:0] drive_pattern;
        logic       port_on;
        logic       changed;
    } t_out;

    // Classified command handed from front to back
    typedef struct packed {
        t_kind      kind;
        logic [2:0] port;
        logic       turn_on;
        logic       port_ok;
    } t_cmd;

    typedef struct packed {
        logic [7:0] rest_limit_seconds;
        logic [7:0] rest_port_mask;
    } t_cfg;

endpackage

>>> rtl/vdl_front.sv
module vdl_front #(
    parameter int PORT_COUNT = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  vdl_pkg::t_in  i_in_data,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output vdl_pkg::t_cmd o_cmd
);

    logic          r_valid;
    logic          n_valid;
    vdl_pkg::t_cmd r_cmd;
    vdl_pkg::t_cmd n_cmd;
    vdl_pkg::t_cmd cls;

    // Decode the action and check the port index
    always_comb begin
        cls.port    = i_in_data.port;
        cls.turn_on = i_in_data.turn_on;
        cls.port_ok = ({29'd0, i_in_data.port} < PORT_COUNT);
        case (i_in_data.action)
            vdl_pkg::ACT_SET:  cls.kind = vdl_pkg::KIND_SET;
            vdl_pkg::ACT_TICK: cls.kind = vdl_pkg::KIND_TICK;
            vdl_pkg::ACT_READ: cls.kind = vdl_pkg::KIND_READ;
            default:           cls.kind = vdl_pkg::KIND_READ;  // unused code reads
        endcase
    end

    assign o_in_ready  = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    // Holding stage: refill when empty or draining into the queue
    always_comb begin
        n_valid = r_valid && !i_cmd_ready;
        n_cmd   = r_cmd;
        if (i_in_valid && o_in_ready) begin
            n_valid = 1'b1;
            n_cmd   = cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

endmodule

>>> rtl/vdl_queue.sv
module vdl_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  vdl_pkg::t_cmd i_push_cmd,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output vdl_pkg::t_cmd o_pop_cmd
);

    vdl_pkg::t_cmd                 r_mem [vdl_pkg::Q_DEPTH];
    logic [vdl_pkg::Q_PTR_W-1:0]   r_wr;
    logic [vdl_pkg::Q_PTR_W-1:0]   r_rd;
    logic [vdl_pkg::Q_CNT_W-1:0]   r_cnt;
    logic                          push;
    logic                          pop;

    assign o_push_ready = (r_cnt != vdl_pkg::Q_CNT_W'(vdl_pkg::Q_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_cmd    = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

endmodule

>>> rtl/vdl_back.sv
module vdl_back #(
    parameter int PORT_COUNT = 8,
    parameter int TIME_BITS  = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  vdl_pkg::t_cfg i_cfg,
    input  logic          i_q_valid,
    output logic          o_q_ready,
    input  vdl_pkg::t_cmd i_q_cmd,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output vdl_pkg::t_out o_out_data
);

    localparam int IDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
    localparam logic [TIME_BITS-1:0] ONE = TIME_BITS'(1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_REPORT = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [TIME_BITS-1:0]  r_now, n_now;
    logic [PORT_COUNT-1:0] r_on, n_on;
    logic [PORT_COUNT-1:0] r_rest, n_rest;
    logic [TIME_BITS-1:0]  r_exp [PORT_COUNT];
    logic [TIME_BITS-1:0]  n_exp [PORT_COUNT];
    logic [IDX_W-1:0]      r_idx, n_idx;
    vdl_pkg::t_cmd         r_cmd, n_cmd;
    logic                  r_changed, n_changed;
    logic                  r_out_valid, n_out_valid;
    vdl_pkg::t_out         r_out, n_out;

    logic [IDX_W-1:0]      q_idx;
    logic                  set_ok;
    logic [TIME_BITS-1:0]  scan_exp;
    logic [TIME_BITS-1:0]  scan_diff;
    logic                  scan_past;
    logic                  scan_prot;
    logic                  scan_force;
    vdl_pkg::t_out         report;

    assign o_q_ready   = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Set admission: present port, real change, not resting
    assign q_idx  = i_q_cmd.port[IDX_W-1:0];
    assign set_ok = i_q_cmd.port_ok && (r_on[q_idx] != i_q_cmd.turn_on) && !r_rest[q_idx];

    // Per-port check of the tick scan; time compare wraps
    assign scan_exp   = r_exp[r_idx];
    assign scan_diff  = r_now - scan_exp;
    assign scan_past  = (scan_diff != '0) && !scan_diff[TIME_BITS-1];
    assign scan_prot  = i_cfg.rest_port_mask[3'(r_idx)];
    assign scan_force = r_on[r_idx] && !r_rest[r_idx] && scan_prot &&
                        (i_cfg.rest_limit_seconds != '0) && scan_past;

    // Result assembled from the flags left by the transaction
    always_comb begin
        report.status_bits   = '0;
        report.resting_bits  = '0;
        report.drive_pattern = 8'hFF;
        for (int i = 0; i < PORT_COUNT; i++) begin
            report.status_bits[i]  = r_on[i];
            report.resting_bits[i] = r_rest[i];
            if (r_on[i]) begin
                report.drive_pattern[vdl_pkg::SEG_OF_PORT[i]] = 1'b0;
            end
        end
        report.port_on = r_cmd.port_ok && r_on[r_cmd.port[IDX_W-1:0]];
        report.changed = r_changed;
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_now       = r_now;
        n_on        = r_on;
        n_rest      = r_rest;
        n_exp       = r_exp;
        n_idx       = r_idx;
        n_cmd       = r_cmd;
        n_changed   = r_changed;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_cmd     = i_q_cmd;
                    n_changed = 1'b0;
                    n_state   = ST_REPORT;
                    case (i_q_cmd.kind)
                        vdl_pkg::KIND_TICK: begin
                            n_now   = r_now + ONE;
                            n_idx   = '0;
                            n_state = ST_SCAN;
                        end
                        vdl_pkg::KIND_SET: begin
                            if (set_ok) begin
                                n_on[q_idx]  = i_q_cmd.turn_on;
                                n_exp[q_idx] = r_now + TIME_BITS'(i_cfg.rest_limit_seconds);
                                n_changed    = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (scan_force) begin
                    // forced off; the new expiry lies ahead, so rest holds
                    n_on[r_idx]   = 1'b0;
                    n_rest[r_idx] = 1'b1;
                    n_exp[r_idx]  = r_now + TIME_BITS'({i_cfg.rest_limit_seconds, 1'b0});
                    n_changed     = 1'b1;
                end else if (r_rest[r_idx] && scan_past) begin
                    n_rest[r_idx] = 1'b0;
                end
                if (r_idx == IDX_W'(PORT_COUNT - 1)) begin
                    n_state = ST_REPORT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_REPORT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = report;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_now       <= '0;
            r_on        <= '0;
            r_rest      <= '0;
            r_idx       <= '0;
            r_changed   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < PORT_COUNT; i++) begin
                r_exp[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_now       <= n_now;
            r_on        <= n_on;
            r_rest      <= n_rest;
            r_idx       <= n_idx;
            r_changed   <= n_changed;
            r_out_valid <= n_out_valid;
            r_exp       <= n_exp;
        end
        r_cmd <= n_cmd;
        r_out <= n_out;
    end

    // A resting port is never on
    a_rest_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_on & r_rest) == '0)
        else $error("port both on and resting");

    // Taking a tick advances time by one
    a_tick_now: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_q_valid && i_q_cmd.kind == vdl_pkg::KIND_TICK)
        |=> (r_now == $past(r_now) + ONE))
        else $error("time counter not advanced by tick");

    // Scan index stays on present ports
    a_scan_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> ({{(32 - IDX_W){1'b0}}, r_idx} < PORT_COUNT))
        else $error("scan index beyond last port");

    // A read never reports a change
    a_read_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REPORT && r_cmd.kind == vdl_pkg::KIND_READ) |-> !r_changed)
        else $error("read transaction flagged a change");

    // Time only moves during the first step of a tick
    a_now_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |=> $stable(r_now))
        else $error("time counter moved outside a tick");

endmodule

>>> rtl/valve_duty_limiter.sv
// Eight-port on/off driver with overheat rest protection. Input transactions
// (set, one-second tick, read) are decoded by a front stage into a two-entry
// command queue, so the input side takes one transaction per cycle until the
// queue fills. The back end runs one command at a time; a tick walks the ports
// one per cycle through the single expiry check before reporting. Each
// transaction yields exactly one result, held in an output register until
// taken. Configuration on the APB port: rest_limit_seconds at 0x0,
// rest_port_mask at 0x4; write only while the block is idle.
module valve_duty_limiter #(
    parameter int PORT_COUNT = 8,
    parameter int TIME_BITS  = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  vdl_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output vdl_pkg::t_out o_out_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    vdl_pkg::t_cfg r_cfg;
    vdl_pkg::t_cfg n_cfg;
    logic          f_valid;
    logic          f_ready;
    vdl_pkg::t_cmd f_cmd;
    logic          q_valid;
    logic          q_ready;
    vdl_pkg::t_cmd q_cmd;

    // Configuration registers
    assign pready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (psel && penable && pwrite) begin
            case (paddr[2])
                vdl_pkg::REG_LIMIT: n_cfg.rest_limit_seconds = pwdata[7:0];
                vdl_pkg::REG_MASK:  n_cfg.rest_port_mask     = pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            vdl_pkg::REG_LIMIT: prdata = {24'd0, r_cfg.rest_limit_seconds};
            vdl_pkg::REG_MASK:  prdata = {24'd0, r_cfg.rest_port_mask};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rest_limit_seconds <= vdl_pkg::LIMIT_RESET;
            r_cfg.rest_port_mask     <= vdl_pkg::MASK_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Decode stage
    vdl_front #(
        .PORT_COUNT (PORT_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (f_ready),
        .o_cmd       (f_cmd)
    );

    // Command queue
    vdl_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_cmd   (f_cmd),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_cmd    (q_cmd)
    );

    // Execution and result register
    vdl_back #(
        .PORT_COUNT (PORT_COUNT),
        .TIME_BITS  (TIME_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .o_q_ready   (q_ready),
        .i_q_cmd     (q_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

>>> test/valve_duty_limiter_tb.sv
`timescale 1ns / 100ps

module valve_duty_limiter_tb;

    // Unused action code, handled by the block as a read
    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES = 250;
    localparam int MAX_SHOWN = 10;

    // Port index -> segment bit of the active-low drive byte, 3 bits per port
    localparam logic [23:0] SEGMENT_MAP = {3'd3, 3'd6, 3'd5, 3'd4, 3'd7, 3'd2, 3'd1, 3'd0};

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_MOSTLY,
        RX_TOGGLE
    } t_rx_mode;

    logic           i_clk;
    logic           i_rst_n = 1'b0;
    logic           i_in_valid = 1'b0;
    logic           o_in_ready;
    vdl_pkg::t_in   i_in_data = '0;
    logic           o_out_valid;
    logic           i_out_ready = 1'b0;
    vdl_pkg::t_out  o_out_data;
    logic           psel = 1'b0;
    logic           penable = 1'b0;
    logic           pwrite = 1'b0;
    logic [2:0]     paddr = '0;
    logic [31:0]    pwdata = '0;
    logic [31:0]    prdata;
    logic           pready;

    valve_duty_limiter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Own copy of the valve state and configuration
    logic [7:0]  cfg_limit = vdl_pkg::LIMIT_RESET;
    logic [7:0]  cfg_mask = vdl_pkg::MASK_RESET;
    logic [31:0] now_s = '0;
    logic [7:0]  on_bits = '0;
    logic [7:0]  rest_bits = '0;
    logic [31:0] expiry [8] = '{default: '0};

    vdl_pkg::t_in  pending_cmds [$];
    vdl_pkg::t_out expected_reports [$];
    int   mismatches = 0;
    int   items_in = 0;
    logic in_taken = 1'b0;

    // Sender burst state
    int burst_left = 0;
    int gap_left = 0;

    // Receiver stall state
    t_rx_mode rx_mode = RX_OPEN;
    int rx_left = 0;
    int hold_left = 0;
    int hold_mark = 300;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // a is strictly later than b on the wrapping time line
    function automatic logic past_due(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 0) && !d[31];
    endfunction

    function automatic logic switch_port(logic [2:0] p, logic want);
        if (on_bits[p] == want || rest_bits[p])
            return 1'b0;
        on_bits[p] = want;
        expiry[p] = now_s + 32'(cfg_limit);
        return 1'b1;
    endfunction

    // Advance the valve state by one transaction and return its report
    function automatic vdl_pkg::t_out apply_valve_item(vdl_pkg::t_in item);
        vdl_pkg::t_out r;
        logic fired;
        fired = 1'b0;
        case (item.action)
            vdl_pkg::ACT_SET: begin
                fired = switch_port(item.port, item.turn_on);
            end
            vdl_pkg::ACT_TICK: begin
                now_s = now_s + 32'd1;
                for (int i = 0; i < 8; i++) begin
                    if (on_bits[i] && !rest_bits[i] && cfg_mask[i] && cfg_limit != 0 &&
                        past_due(now_s, expiry[i])) begin
                        on_bits[i] = 1'b0;
                        rest_bits[i] = 1'b1;
                        expiry[i] = now_s + 2 * 32'(cfg_limit);
                        fired = 1'b1;
                    end
                    if (rest_bits[i] && past_due(now_s, expiry[i]))
                        rest_bits[i] = 1'b0;
                end
            end
            default: ;
        endcase
        r.status_bits = on_bits;
        r.resting_bits = rest_bits;
        r.drive_pattern = 8'hFF;
        for (int i = 0; i < 8; i++)
            if (on_bits[i])
                r.drive_pattern[SEGMENT_MAP[3*i +: 3]] = 1'b0;
        r.port_on = on_bits[item.port];
        r.changed = fired;
        return r;
    endfunction

    function automatic void flag_mismatch(string what, int want, int got);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("mismatch %s: expected %0h got %0h", what, want, got);
    endfunction

    function automatic void check_report(vdl_pkg::t_out got, vdl_pkg::t_out want);
        if (got.status_bits !== want.status_bits)
            flag_mismatch("status_bits", int'(want.status_bits), int'(got.status_bits));
        if (got.resting_bits !== want.resting_bits)
            flag_mismatch("resting_bits", int'(want.resting_bits), int'(got.resting_bits));
        if (got.drive_pattern !== want.drive_pattern)
            flag_mismatch("drive_pattern", int'(want.drive_pattern),
                          int'(got.drive_pattern));
        if (got.port_on !== want.port_on)
            flag_mismatch("port_on", int'(want.port_on), int'(got.port_on));
        if (got.changed !== want.changed)
            flag_mismatch("changed", int'(want.changed), int'(got.changed));
    endfunction

    // Monitor: results checked before the same edge's new transaction is predicted
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_reports.size() == 0)
                    flag_mismatch("result with none pending", 0, int'(o_out_data));
                else
                    check_report(o_out_data, expected_reports.pop_front());
            end
            if (i_in_valid && o_in_ready) begin
                expected_reports.push_back(apply_valve_item(i_in_data));
                items_in++;
            end
        end
    end

    // Driver: bursts of transactions separated by random gaps
    always @(negedge i_clk) begin
        logic         nv;
        vdl_pkg::t_in nd;
        nv = i_in_valid;
        nd = i_in_data;
        if (in_taken)
            nv = 1'b0;
        if (!nv) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_cmds.size() != 0) begin
                nd = pending_cmds.pop_front();
                nv = 1'b1;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
        i_in_valid <= nv;
        i_in_data <= nd;
    end

    // Receiver: stall pattern by mode, plus long hold-offs to back up the input
    always @(negedge i_clk) begin
        logic nr;
        if (hold_left > 0) begin
            hold_left--;
            nr = 1'b0;
        end else if (hold_mark != 0 && items_in >= hold_mark) begin
            hold_left = HOLD_CYCLES;
            hold_mark = (hold_mark == 300) ? 1000 : 0;
            nr = 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            case (rx_mode)
                RX_OPEN:   nr = 1'b1;
                RX_COIN:   nr = 1'($urandom_range(0, 1));
                RX_MOSTLY: nr = ($urandom_range(0, 3) != 0);
                default:   nr = ~i_out_ready;
            endcase
        end
        i_out_ready <= nr;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("simulation failed");
        $finish;
    end

    task automatic push_cmd(logic [1:0] action, logic [2:0] port, logic turn_on);
        vdl_pkg::t_in it;
        it.action = action;
        it.port = port;
        it.turn_on = turn_on;
        pending_cmds.push_back(it);
    endtask

    task automatic wait_idle();
        @(posedge i_clk);
        while (pending_cmds.size() != 0 || i_in_valid || expected_reports.size() != 0)
            @(posedge i_clk);
    endtask

    // APB write then read back, register chosen by its index bit
    task automatic cfg_write(logic reg_idx, logic [7:0] value);
        logic [7:0] got;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= {24'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (reg_idx == vdl_pkg::REG_LIMIT)
            cfg_limit = value;
        else
            cfg_mask = value;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        got = prdata[7:0];
        if (got !== value)
            flag_mismatch("register readback", int'(value), int'(got));
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(logic [7:0] limit, logic [7:0] mask);
        wait_idle();
        cfg_write(vdl_pkg::REG_LIMIT, limit);
        cfg_write(vdl_pkg::REG_MASK, mask);
    endtask

    // Random transactions; tick_pct sets how often time advances
    task automatic run_random(logic [7:0] limit, logic [7:0] mask, int count, int tick_pct);
        int roll;
        logic [1:0] act;
        set_config(limit, mask);
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < tick_pct)
                act = vdl_pkg::ACT_TICK;
            else if (roll < 90)
                act = vdl_pkg::ACT_SET;
            else if (roll < 97)
                act = vdl_pkg::ACT_READ;
            else
                act = ACT_SPARE;
            push_cmd(act, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: unprotected and protected ports, repeats, spare code
        push_cmd(vdl_pkg::ACT_READ, 3'd0, 1'b1);
        push_cmd(vdl_pkg::ACT_SET, 3'd0, 1'b1);
        push_cmd(vdl_pkg::ACT_SET, 3'd0, 1'b1);
        push_cmd(vdl_pkg::ACT_SET, 3'd7, 1'b1);
        push_cmd(ACT_SPARE, 3'd7, 1'b1);
        push_cmd(vdl_pkg::ACT_TICK, 3'd7, 1'b1);
        push_cmd(vdl_pkg::ACT_SET, 3'd0, 1'b0);
        push_cmd(vdl_pkg::ACT_SET, 3'd3, 1'b1);
        push_cmd(vdl_pkg::ACT_SET, 3'd7, 1'b0);

        // One-second limit: forced rest, sets refused while resting, rest ending
        set_config(8'd1, 8'hFF);
        push_cmd(vdl_pkg::ACT_SET, 3'd5, 1'b1);
        push_cmd(vdl_pkg::ACT_TICK, 3'd5, 1'b0);
        push_cmd(vdl_pkg::ACT_TICK, 3'd5, 1'b0);
        push_cmd(vdl_pkg::ACT_SET, 3'd5, 1'b1);
        push_cmd(vdl_pkg::ACT_SET, 3'd5, 1'b0);
        push_cmd(vdl_pkg::ACT_TICK, 3'd5, 1'b1);
        push_cmd(vdl_pkg::ACT_TICK, 3'd5, 1'b1);
        push_cmd(vdl_pkg::ACT_TICK, 3'd5, 1'b1);
        push_cmd(vdl_pkg::ACT_SET, 3'd5, 1'b1);

        // Zero limit: protected ports never forced off
        set_config(8'd0, 8'hFF);
        push_cmd(vdl_pkg::ACT_SET, 3'd6, 1'b1);
        push_cmd(vdl_pkg::ACT_TICK, 3'd6, 1'b0);
        push_cmd(vdl_pkg::ACT_TICK, 3'd6, 1'b0);
        push_cmd(vdl_pkg::ACT_TICK, 3'd6, 1'b0);
        push_cmd(vdl_pkg::ACT_READ, 3'd6, 1'b0);

        run_random(8'd0, 8'hFF, 150, 40);
        run_random(8'd1, 8'hFF, 300, 40);
        run_random(8'd3, 8'($urandom_range(0, 255)), 300, 45);
        run_random(8'd255, 8'hFF, 400, 75);
        run_random(8'd5, 8'h00, 100, 40);
        run_random(8'($urandom_range(2, 8)), 8'($urandom_range(0, 255)), 350, 40);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
